### design/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and constants shared by the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	// Input limits
	localparam logic [6:0] PCT_MAX    = 7'd100;
	localparam logic [8:0] HUE_LIMIT  = 9'd360;
	localparam logic [5:0] SECTOR_DEG = 6'd60;

	// One percent of value at the common scale of 600000
	localparam logic [12:0] FULL_STEP = 13'd6000;

	// Scaled channel width and the width after the multiply by 17
	localparam int unsigned NUM_W = 20;
	localparam int unsigned N17_W = 24;

	// Division by 625 through a reciprocal: floor(2^18 / 625)
	localparam logic [8:0]  RECIP       = 9'd419;
	localparam int unsigned RECIP_SHIFT = 18;
	localparam logic [9:0]  DIV_625     = 10'd625;

	// Hue sector codes, 60 degrees each
	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;

	// Per-channel numerators times 17, before the division by 40000
	typedef struct packed {
		logic [N17_W-1:0] r;
		logic [N17_W-1:0] g;
		logic [N17_W-1:0] b;
	} chan_nums_t;

endpackage

### design/hsv_to_rgb_percent.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_percent
// HSV to 8-bit RGB conversion, hue in degrees, saturation and value in
// percent. Exact fixed-point arithmetic, channels truncated toward zero.
// ----------------------------------------------------------------------------
// Takes one pixel per clock: start is accepted in any cycle and busy is
// always low. Each transaction gives its result on red, green and blue,
// marked by a one-cycle done strobe, after the three conversion stages
// and the two stages of the divide by 625. Results cannot be held off,
// so the receiver must take done when it arrives. A hue of 360 or more
// gives black; saturation and value above 100 are treated as 100.
module hsv_to_rgb_percent
	import hsvrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [8:0] hue,
	input  logic [6:0] saturation,
	input  logic [6:0] brightness,
	output logic       done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic       vld_s3;
	chan_nums_t nums_s3;
	logic       vld_s4, vld_s5;

	// Never stalls
	assign busy = 1'b0;

	// Sector select and chroma terms
	hsvrgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (vld_s3),
		.nums       (nums_s3)
	);

	// Per-channel scaling to 0..255
	hsvrgb_scale u_scale_r (.clk(clk), .num(nums_s3.r), .chan(red));
	hsvrgb_scale u_scale_g (.clk(clk), .num(nums_s3.g), .chan(green));
	hsvrgb_scale u_scale_b (.clk(clk), .num(nums_s3.b), .chan(blue));

	// Valid follows the scaling stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign done = vld_s5;

endmodule

### design/hsvrgb_front.sv
// ----------------------------------------------------------------------------
// hsvrgb_front
// Clamps the inputs, finds the hue sector and distance, forms the chroma
// terms and selects the three channel numerators, times 17. Three register stages.
// ----------------------------------------------------------------------------
module hsvrgb_front
	import hsvrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [8:0] hue,
	input  logic [6:0] saturation,
	input  logic [6:0] brightness,
	output logic       out_valid,
	output chan_nums_t nums
);

	logic [6:0]  sat_c, val_c;
	logic [2:0]  sec_c;
	logic [8:0]  base_c;
	logic [6:0]  hm_c;
	logic [5:0]  dist_c;
	logic [8:0]  hm_full;

	logic        vld_s1, vld_s2, vld_s3;
	logic        blk_s1, blk_s2;
	logic [2:0]  sec_s1, sec_s2;
	logic [5:0]  dist_s1;
	logic [13:0] vs_s1;
	logic [6:0]  val_s1;
	logic [NUM_W-1:0] full_s2, vd_s2, v60_s2;

	logic [NUM_W-1:0] mid_c, zero_c, r_c, g_c, b_c;
	chan_nums_t  nums_s3;

	// Clamp percentages
	assign sat_c = (saturation > PCT_MAX) ? PCT_MAX : saturation;
	assign val_c = (brightness > PCT_MAX) ? PCT_MAX : brightness;

	// Sector and distance from the centre of the 120-degree pair
	always_comb begin
		if (hue < 9'd60) begin
			sec_c  = SEC_0;
			base_c = 9'd0;
		end else if (hue < 9'd120) begin
			sec_c  = SEC_1;
			base_c = 9'd0;
		end else if (hue < 9'd180) begin
			sec_c  = SEC_2;
			base_c = 9'd120;
		end else if (hue < 9'd240) begin
			sec_c  = SEC_3;
			base_c = 9'd120;
		end else if (hue < 9'd300) begin
			sec_c  = SEC_4;
			base_c = 9'd240;
		end else begin
			sec_c  = SEC_5;
			base_c = 9'd240;
		end
	end

	assign hm_full = hue - base_c;
	assign hm_c    = hm_full[6:0];
	assign dist_c  = (hm_c >= 7'(SECTOR_DEG)) ? 6'(hm_c - 7'(SECTOR_DEG))
	                                          : 6'(7'(SECTOR_DEG) - hm_c);

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: sector, distance and v*s
	always_ff @(posedge clk) begin
		blk_s1  <= (hue >= HUE_LIMIT);
		sec_s1  <= sec_c;
		dist_s1 <= dist_c;
		vs_s1   <= 14'(sat_c) * 14'(val_c);
		val_s1  <= val_c;
	end

	// Stage 2: scaled products
	always_ff @(posedge clk) begin
		blk_s2  <= blk_s1;
		sec_s2  <= sec_s1;
		full_s2 <= NUM_W'(val_s1) * NUM_W'(FULL_STEP);
		vd_s2   <= NUM_W'(vs_s1) * NUM_W'(dist_s1);
		v60_s2  <= NUM_W'(vs_s1) * NUM_W'(SECTOR_DEG);
	end

	// Channel terms; never negative since v*s*60 <= v*6000
	assign mid_c  = full_s2 - vd_s2;
	assign zero_c = full_s2 - v60_s2;

	// Channel order by sector; out-of-range hue gives black
	always_comb begin
		unique case (sec_s2)
			SEC_0: begin r_c = full_s2; g_c = mid_c;   b_c = zero_c;  end
			SEC_1: begin r_c = mid_c;   g_c = full_s2; b_c = zero_c;  end
			SEC_2: begin r_c = zero_c;  g_c = full_s2; b_c = mid_c;   end
			SEC_3: begin r_c = zero_c;  g_c = mid_c;   b_c = full_s2; end
			SEC_4: begin r_c = mid_c;   g_c = zero_c;  b_c = full_s2; end
			default: begin r_c = full_s2; g_c = zero_c; b_c = mid_c;  end
		endcase
		if (blk_s2) begin
			r_c = '0;
			g_c = '0;
			b_c = '0;
		end
	end

	// Stage 3: times 17 as shift and add (255/600000 = 17/40000)
	always_ff @(posedge clk) begin
		nums_s3.r <= N17_W'(r_c) + (N17_W'(r_c) << 4);
		nums_s3.g <= N17_W'(g_c) + (N17_W'(g_c) << 4);
		nums_s3.b <= N17_W'(b_c) + (N17_W'(b_c) << 4);
	end

	assign out_valid = vld_s3;
	assign nums      = nums_s3;

endmodule

### design/hsvrgb_scale.sv
// ----------------------------------------------------------------------------
// hsvrgb_scale
// Divides one channel numerator by 40000: a shift by 6, then division by
// 625 through a reciprocal multiply and one correction step. Two stages.
// ----------------------------------------------------------------------------
module hsvrgb_scale
	import hsvrgb_pkg::*;
(
	input  logic             clk,
	input  logic [N17_W-1:0] num,
	output logic [7:0]       chan
);

	localparam int unsigned T_W = N17_W - 6;
	localparam int unsigned P_W = T_W + 9;

	logic [T_W-1:0] t_c;
	logic [P_W-1:0] prod_c;
	logic [T_W-1:0] t_s4;
	logic [7:0]     q_s4;
	logic [T_W-1:0] rem_c;
	logic [7:0]     chan_s5;

	// Estimate is the quotient or one below it
	assign t_c    = num[N17_W-1:6];
	assign prod_c = P_W'(t_c) * P_W'(RECIP);

	always_ff @(posedge clk) begin
		t_s4 <= t_c;
		q_s4 <= prod_c[RECIP_SHIFT+7:RECIP_SHIFT];
	end

	// Correct the estimate from the remainder
	assign rem_c = t_s4 - T_W'(q_s4) * T_W'(DIV_625);

	always_ff @(posedge clk) begin
		chan_s5 <= (rem_c >= T_W'(DIV_625)) ? q_s4 + 8'd1 : q_s4;
	end

	assign chan = chan_s5;

endmodule

### tb/sv/tb_hsv_to_rgb_percent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_percent
// Self-checking bench for the HSV to RGB converter. A queue of pixels drives
// start with random idle gaps and bursts with no gaps. Each transaction's
// colour is predicted exactly and checked against the done-strobed result,
// in order. Hue sector edges, out-of-range hue and clamped percentages are
// covered first, then about 500 random pixels follow.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_percent
	import hsvrgb_pkg::*;
();

	localparam int unsigned CHAN_FULL    = 255;
	localparam int unsigned COMMON_SCALE = 600000;
	localparam int unsigned LATENCY      = 5;
	localparam int unsigned N_RANDOM     = 500;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] bri;
		logic [3:0] wait_cycles;
	} pixel_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [8:0] hue;
	logic [6:0] saturation;
	logic [6:0] brightness;
	logic       done;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	pixel_t      pixel_q[$];
	rgb_t        colour_q[$];
	int unsigned wait_cnt  = 0;
	int unsigned cycle_cnt = 0;
	int unsigned n_sent    = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors  = 0;
	int unsigned n_black   = 0;
	int unsigned n_clamped = 0;

	hsv_to_rgb_percent i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	// Clock
	always #6 clk = ~clk;

	// Exact colour of one pixel, all terms at a common scale of 600000
	function automatic rgb_t rgb_from_hsv(input logic [8:0] h, input logic [6:0] s_in,
			input logic [6:0] v_in);
		int unsigned s, v, vs, hm, hue_dist, full, mid, zero;
		int unsigned r_num, g_num, b_num;
		logic [2:0]  sector;
		rgb_t        rgb;
		s = (s_in > PCT_MAX) ? PCT_MAX : s_in;
		v = (v_in > PCT_MAX) ? PCT_MAX : v_in;
		if (h >= HUE_LIMIT)
			return '0;
		vs   = v * s;
		hm   = h % (2 * SECTOR_DEG);
		hue_dist = (hm >= SECTOR_DEG) ? (hm - SECTOR_DEG) : (SECTOR_DEG - hm);
		full = v * FULL_STEP;
		mid  = full - vs * hue_dist;
		zero = full - vs * SECTOR_DEG;
		sector = 3'(h / SECTOR_DEG);
		case (sector)
			SEC_0: begin r_num = full; g_num = mid;  b_num = zero; end
			SEC_1: begin r_num = mid;  g_num = full; b_num = zero; end
			SEC_2: begin r_num = zero; g_num = full; b_num = mid;  end
			SEC_3: begin r_num = zero; g_num = mid;  b_num = full; end
			SEC_4: begin r_num = mid;  g_num = zero; b_num = full; end
			default: begin r_num = full; g_num = zero; b_num = mid; end
		endcase
		rgb.r = 8'((r_num * CHAN_FULL) / COMMON_SCALE);
		rgb.g = 8'((g_num * CHAN_FULL) / COMMON_SCALE);
		rgb.b = 8'((b_num * CHAN_FULL) / COMMON_SCALE);
		return rgb;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	task automatic add_pixel(input int h, input int s, input int v, input int gap);
		pixel_t p;
		p.hue         = 9'(h);
		p.sat         = 7'(s);
		p.bri         = 7'(v);
		p.wait_cycles = 4'(gap);
		pixel_q.push_back(p);
	endtask

	// Draw a percentage: mostly in range, some extremes, some above 100
	function automatic int draw_pct();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			return $urandom_range(0, 100);
		else if (pick < 87)
			return ($urandom_range(0, 1) != 0) ? 100 : 0;
		else
			return $urandom_range(101, 127);
	endfunction

	// Driver: takes the next pixel once its idle gap has passed
	always @(posedge clk) begin : driver
		pixel_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				colour_q.push_back(rgb_from_hsv(hue, saturation, brightness));
				n_sent++;
				if (hue >= HUE_LIMIT)
					n_black++;
				if (saturation > PCT_MAX || brightness > PCT_MAX)
					n_clamped++;
			end
			if (start && busy) begin
				// transaction not taken yet, hold it
			end else if (pixel_q.size() == 0) begin
				start <= 1'b0;
			end else if (wait_cnt < pixel_q[0].wait_cycles) begin
				wait_cnt++;
				start <= 1'b0;
			end else begin
				nxt = pixel_q.pop_front();
				wait_cnt = 0;
				start      <= 1'b1;
				hue        <= nxt.hue;
				saturation <= nxt.sat;
				brightness <= nxt.bri;
			end
		end
	end

	// Monitor: every done strobe is checked against the oldest expectation
	always @(posedge clk) begin : monitor
		rgb_t want;
		if (arst_n && done) begin
			if (colour_q.size() == 0) begin
				report_mismatch("unexpected result (red)", red, 0);
			end else begin
				want = colour_q.pop_front();
				n_checked++;
				if (red !== want.r)
					report_mismatch("red", red, want.r);
				if (green !== want.g)
					report_mismatch("green", green, want.g);
				if (blue !== want.b)
					report_mismatch("blue", blue, want.b);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				colour_q.size());
			$display("[hsv_to_rgb_percent] ERROR");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		int unsigned pick;
		int          h, gap;
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		hue        = '0;
		saturation = '0;
		brightness = '0;

		// Sector edges at full colour, black hue, clamping and zero corners
		add_pixel(0, 100, 100, $urandom_range(0, 11));
		add_pixel(59, 100, 100, $urandom_range(0, 11));
		add_pixel(60, 100, 100, $urandom_range(0, 11));
		add_pixel(119, 100, 100, $urandom_range(0, 11));
		add_pixel(120, 100, 100, $urandom_range(0, 11));
		add_pixel(179, 100, 100, $urandom_range(0, 11));
		add_pixel(180, 100, 100, $urandom_range(0, 11));
		add_pixel(239, 100, 100, $urandom_range(0, 11));
		add_pixel(240, 100, 100, $urandom_range(0, 11));
		add_pixel(299, 100, 100, $urandom_range(0, 11));
		add_pixel(300, 100, 100, $urandom_range(0, 11));
		add_pixel(359, 100, 100, $urandom_range(0, 11));
		add_pixel(360, 100, 100, 0);
		add_pixel(511, 127, 127, 0);
		add_pixel(0, 0, 0, 0);
		add_pixel(30, 0, 100, $urandom_range(0, 11));
		add_pixel(90, 100, 0, $urandom_range(0, 11));
		add_pixel(200, 127, 50, $urandom_range(0, 11));
		add_pixel(330, 50, 127, 0);
		add_pixel(45, 101, 101, 0);
		add_pixel(150, 37, 83, $urandom_range(0, 11));
		add_pixel(270, 1, 1, $urandom_range(0, 11));
		add_pixel(15, 64, 99, 0);

		// Random pixels; every fifth stretch of twenty runs back to back
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 78)
				h = $urandom_range(0, 359);
			else if (pick < 88)
				h = 60 * $urandom_range(0, 5) + (($urandom_range(0, 1) != 0) ? 59 : 0);
			else
				h = $urandom_range(360, 511);
			gap = ((i / 20) % 5 == 2) ? 0 : $urandom_range(0, 11);
			add_pixel(h, draw_pct(), draw_pct(), gap);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_q.size() != 0 || start || colour_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);

		if (colour_q.size() != 0)
			report_mismatch("results never delivered", 0, colour_q.size());
		$display("%0d pixels converted, %0d with hue past 359, %0d with clamped percentages",
			n_sent, n_black, n_clamped);
		$display("%0d results checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0)
			$display("[hsv_to_rgb_percent] OK");
		else
			$display("[hsv_to_rgb_percent] ERROR");
		$finish;
	end

endmodule

### filelist.f
design/hsvrgb_pkg.sv
design/hsvrgb_front.sv
design/hsvrgb_scale.sv
design/hsv_to_rgb_percent.sv
tb/sv/tb_hsv_to_rgb_percent.sv
